@@ rtl/core/nearest_climate_box_select_top_defines.svh @@
// Assertion macros shared by the nearest climate box select RTL
`ifndef NEAREST_CLIMATE_BOX_SELECT_TOP_DEFINES_SVH
`define NEAREST_CLIMATE_BOX_SELECT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset
`define NCBS_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ncbs: invariant violated");
// Antecedent in one cycle implies consequent in the next
`define NCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ncbs: sequence violated");
`else
`define NCBS_ASSERT(label, clk, rst_n, expr)
`define NCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/ncbs_pkg.sv @@
// Package of types and constants for the nearest climate box select block
`timescale 1ns / 1ps
`default_nettype none

package ncbs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int VALUE_BITS  = 16;
    localparam int KEY_W       = 16;
    localparam int SCORE_W     = 38;
    localparam int FUNC_W      = 2;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W = KEY_W + 4 * VALUE_BITS;

    // doubled-unit distance pipeline widths
    localparam int OFF_W = VALUE_BITS + 2;
    localparam int WID_W = VALUE_BITS + 1;
    localparam int D_W   = VALUE_BITS + 2;
    localparam int A_W   = D_W + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CLEAR,
        S_COMMIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic select;
        logic clear;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/ncbs_ram.sv @@
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module ncbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/ncbs_ctrl.sv @@
// Controller state machine sequencing insert, clear and select operations
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_climate_box_select_top_defines.svh"

module ncbs_ctrl
    import ncbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd,
    output logic                   o_busy,
    output logic                   o_valid
);

    t_state r_state, n_state;
    logic   r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_sel = (i_func == FUNC_SELECT);
                    priority case (i_func)
                        FUNC_INSERT: n_state = S_SCAN;
                        FUNC_SELECT: n_state = S_SCAN;
                        FUNC_CLEAR:  n_state = S_CLEAR;
                        default:     n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = r_sel ? S_FINISH : S_COMMIT;
                end
            end
            S_CLEAR:  n_state = S_FINISH;
            S_COMMIT: n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.select = r_sel;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.commit = (r_state == S_COMMIT);
        o_busy       = (r_state != S_IDLE);
        o_valid      = (r_state == S_FINISH);
    end

    `NCBS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `NCBS_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid && !o_busy)

endmodule

`default_nettype wire

@@ rtl/core/ncbs_dp.sv @@
// Datapath: slot table, key match, distance scoring pipeline and result registers
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_climate_box_select_top_defines.svh"

module ncbs_dp
    import ncbs_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_stat                             o_stat,
    input  wire logic        [KEY_W-1:0]      i_entry_key,
    input  wire logic signed [VALUE_BITS-1:0] i_temp_min,
    input  wire logic signed [VALUE_BITS-1:0] i_temp_max,
    input  wire logic signed [VALUE_BITS-1:0] i_hum_min,
    input  wire logic signed [VALUE_BITS-1:0] i_hum_max,
    input  wire logic signed [VALUE_BITS-1:0] i_query_temp,
    input  wire logic signed [VALUE_BITS-1:0] i_query_hum,
    output logic             [KEY_W-1:0]      o_best_key,
    output logic                              o_found,
    output logic             [SCORE_W-1:0]    o_best_score,
    output logic             [CNT_W-1:0]      o_entry_count,
    output logic                              o_status
);

    // latched operands
    logic        [KEY_W-1:0]      r_key;
    logic signed [VALUE_BITS-1:0] r_tmin, r_tmax, r_hmin, r_hmax, r_qt, r_qh;

    // table control
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_status;

    // pipeline tags
    logic             r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [IDX_W-1:0] r_i0;

    // pipeline payload
    logic signed [OFF_W-1:0]   r_off_t, r_off_h;
    logic signed [WID_W-1:0]   r_wid_t, r_wid_h;
    logic        [D_W-1:0]     r_d_t, r_d_h;
    logic        [SQ_W-1:0]    r_sq_t, r_sq_h;
    logic        [SCORE_W-1:0] r_sc4;
    logic        [KEY_W-1:0]   r_k1, r_k2, r_k3, r_k4;

    // best so far
    logic               r_found;
    logic [SCORE_W-1:0] r_best_score;
    logic [KEY_W-1:0]   r_best_key;

    logic             rd_en;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] rdata;
    logic             full;

    logic        [KEY_W-1:0]      rd_key;
    logic signed [VALUE_BITS-1:0] rd_tmin, rd_tmax, rd_hmin, rd_hmax;
    logic signed [OFF_W-1:0]      n_off_t, n_off_h;
    logic signed [WID_W-1:0]      n_wid_t, n_wid_h;
    logic        [OFF_W-1:0]      abs_t, abs_h;
    logic signed [A_W-1:0]        a_t, a_h;
    logic        [D_W-1:0]        n_d_t, n_d_h;
    logic        [SUM_W-1:0]      sum;
    logic        [CMP_W-1:0]      sum_x, max_x;
    logic        [SCORE_W-1:0]    n_sc4;

    assign full      = (r_count == CNT_W'(MAX_ENTRIES));
    assign rd_en     = i_cmd.scan && (r_idx < r_count);
    assign ram_we    = i_cmd.commit && (r_hit || !full);
    assign ram_waddr = r_hit ? r_hit_idx : r_count[IDX_W-1:0];
    assign ram_wdata = {r_key, r_tmin, r_tmax, r_hmin, r_hmax};

    ncbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign {rd_key, rd_tmin, rd_tmax, rd_hmin, rd_hmax} = rdata;

    // stage 1: doubled offset of the query from the box centre, and box width
    always_comb begin
        n_off_t = (OFF_W'(r_qt) <<< 1) - (OFF_W'(rd_tmin) + OFF_W'(rd_tmax));
        n_off_h = (OFF_W'(r_qh) <<< 1) - (OFF_W'(rd_hmin) + OFF_W'(rd_hmax));
        n_wid_t = WID_W'(rd_tmax) - WID_W'(rd_tmin);
        n_wid_h = WID_W'(rd_hmax) - WID_W'(rd_hmin);
    end

    // stage 2: distance outside the box, zero inside
    always_comb begin
        abs_t = r_off_t[OFF_W-1] ? OFF_W'(-r_off_t) : OFF_W'(r_off_t);
        abs_h = r_off_h[OFF_W-1] ? OFF_W'(-r_off_h) : OFF_W'(r_off_h);
        a_t   = signed'(A_W'(abs_t)) - A_W'(r_wid_t);
        a_h   = signed'(A_W'(abs_h)) - A_W'(r_wid_h);
        n_d_t = a_t[A_W-1] ? '0 : a_t[D_W-1:0];
        n_d_h = a_h[A_W-1] ? '0 : a_h[D_W-1:0];
    end

    // stage 4: sum of squares, saturated to the score width
    always_comb begin
        sum   = SUM_W'(r_sq_t) + SUM_W'(r_sq_h);
        sum_x = CMP_W'(sum);
        max_x = CMP_W'({SCORE_W{1'b1}});
        n_sc4 = (sum_x > max_x) ? {SCORE_W{1'b1}} : sum_x[SCORE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_status <= 1'b0;
            r_found  <= 1'b0;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
        end else begin
            r_v0 <= rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_status <= 1'b0;
                r_found  <= 1'b0;
            end
            if (rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            // hold the first slot whose key matches
            if (r_v0 && !i_cmd.select && !r_hit && (rd_key == r_key)) begin
                r_hit <= 1'b1;
            end
            if (r_v4 && i_cmd.select && (!r_found || (r_sc4 < r_best_score))) begin
                r_found <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.commit && !r_hit) begin
                if (full) begin
                    r_status <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key        <= i_entry_key;
            r_tmin       <= i_temp_min;
            r_tmax       <= i_temp_max;
            r_hmin       <= i_hum_min;
            r_hmax       <= i_hum_max;
            r_qt         <= i_query_temp;
            r_qh         <= i_query_hum;
            r_best_score <= '0;
            r_best_key   <= '0;
        end
        r_i0 <= r_idx[IDX_W-1:0];
        if (r_v0 && !i_cmd.select && !r_hit && (rd_key == r_key)) begin
            r_hit_idx <= r_i0;
        end
        r_off_t <= n_off_t;
        r_off_h <= n_off_h;
        r_wid_t <= n_wid_t;
        r_wid_h <= n_wid_h;
        r_k1    <= rd_key;
        r_d_t   <= n_d_t;
        r_d_h   <= n_d_h;
        r_k2    <= r_k1;
        r_sq_t  <= SQ_W'(r_d_t) * SQ_W'(r_d_t);
        r_sq_h  <= SQ_W'(r_d_h) * SQ_W'(r_d_h);
        r_k3    <= r_k2;
        r_sc4   <= n_sc4;
        r_k4    <= r_k3;
        // ties keep the earlier slot
        if (r_v4 && i_cmd.select && (!r_found || (r_sc4 < r_best_score))) begin
            r_best_score <= r_sc4;
            r_best_key   <= r_k4;
        end
    end

    assign o_stat.scan_done = (r_idx >= r_count) && !r_v0 && !r_v1 && !r_v2 && !r_v3 && !r_v4;

    assign o_best_key    = r_best_key;
    assign o_found       = r_found;
    assign o_best_score  = r_best_score;
    assign o_entry_count = r_count;
    assign o_status      = r_status;

    `NCBS_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(MAX_ENTRIES))
    `NCBS_ASSERT(a_found_needs_entry, i_clk, i_rst_n, !r_found || (r_count != '0))
    `NCBS_ASSERT_NEXT(a_append_counts, i_clk, i_rst_n, i_cmd.commit && !r_hit && !full, r_count == $past(r_count) + CNT_W'(1))

endmodule

`default_nettype wire

@@ rtl/core/nearest_climate_box_select_top.sv @@
// Top level of the nearest climate box select block
//
//  channel   direction  handshake            payload
//  command   in         start high, busy low func, entry_key, bounds, query point
//  result    out        o_valid, one cycle   best_key, found, best_score, entry_count, status
//
// Insert and select step through the filled slots (up to 64) one per cycle on
// the table RAM read port; insert then writes its slot or flags status when the
// table is full, and an unused code goes straight to the result strobe. Valid
// slots are always the lowest entry_count indices, so reset and clear only zero
// the fill count. Results cannot be stalled: o_valid stands for one cycle and
// busy drops in the next.
`timescale 1ns / 1ps
`default_nettype none

module nearest_climate_box_select_top
    import ncbs_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic        [FUNC_W-1:0]     i_func,
    input  wire logic        [KEY_W-1:0]      i_entry_key,
    input  wire logic signed [VALUE_BITS-1:0] i_temp_min,
    input  wire logic signed [VALUE_BITS-1:0] i_temp_max,
    input  wire logic signed [VALUE_BITS-1:0] i_hum_min,
    input  wire logic signed [VALUE_BITS-1:0] i_hum_max,
    input  wire logic signed [VALUE_BITS-1:0] i_query_temp,
    input  wire logic signed [VALUE_BITS-1:0] i_query_hum,
    output logic                              o_valid,
    output logic             [KEY_W-1:0]      o_best_key,
    output logic                              o_found,
    output logic             [SCORE_W-1:0]    o_best_score,
    output logic             [CNT_W-1:0]      o_entry_count,
    output logic                              o_status
);

    t_cmd  cmd;
    t_stat stat;

    ncbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ncbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_entry_key   (i_entry_key),
        .i_temp_min    (i_temp_min),
        .i_temp_max    (i_temp_max),
        .i_hum_min     (i_hum_min),
        .i_hum_max     (i_hum_max),
        .i_query_temp  (i_query_temp),
        .i_query_hum   (i_query_hum),
        .o_best_key    (o_best_key),
        .o_found       (o_found),
        .o_best_score  (o_best_score),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

@@ tb/tb_nearest_climate_box_select_top.sv @@
// Self-checking testbench for the nearest climate box select block
`timescale 1ns / 1ps

module tb_nearest_climate_box_select_top;
    import ncbs_pkg::*;

    localparam logic [FUNC_W-1:0]  FUNC_NOP       = 2'd3;
    localparam longint             SCORE_CEIL     = (longint'(1) << SCORE_W) - 1;
    localparam int                 RANDOM_WORDS   = 1350;
    localparam int                 DRAIN_CYCLES   = 100;
    localparam int                 WATCHDOG_LIMIT = 1000;
    localparam logic signed [VALUE_BITS-1:0] V_MIN = 16'sh8000;
    localparam logic signed [VALUE_BITS-1:0] V_MAX = 16'sh7FFF;

    typedef struct {
        logic [FUNC_W-1:0]            func;
        logic [KEY_W-1:0]             key;
        logic signed [VALUE_BITS-1:0] t_lo;
        logic signed [VALUE_BITS-1:0] t_hi;
        logic signed [VALUE_BITS-1:0] h_lo;
        logic signed [VALUE_BITS-1:0] h_hi;
        logic signed [VALUE_BITS-1:0] q_t;
        logic signed [VALUE_BITS-1:0] q_h;
    } climate_cmd_t;

    typedef struct {
        logic [KEY_W-1:0]   key;
        logic               found;
        logic [SCORE_W-1:0] score;
        logic [CNT_W-1:0]   count;
        logic               status;
    } climate_reply_t;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [FUNC_W-1:0]            i_func;
    logic [KEY_W-1:0]             i_entry_key;
    logic signed [VALUE_BITS-1:0] i_temp_min;
    logic signed [VALUE_BITS-1:0] i_temp_max;
    logic signed [VALUE_BITS-1:0] i_hum_min;
    logic signed [VALUE_BITS-1:0] i_hum_max;
    logic signed [VALUE_BITS-1:0] i_query_temp;
    logic signed [VALUE_BITS-1:0] i_query_hum;
    logic                         o_valid;
    logic [KEY_W-1:0]             o_best_key;
    logic                         o_found;
    logic [SCORE_W-1:0]           o_best_score;
    logic [CNT_W-1:0]             o_entry_count;
    logic                         o_status;

    // shadow copy of the box table
    bit                           box_used [MAX_ENTRIES];
    logic [KEY_W-1:0]             box_key  [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] box_t_lo [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] box_t_hi [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] box_h_lo [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] box_h_hi [MAX_ENTRIES];
    int                           box_fill;

    climate_reply_t box_replies_due [$];

    logic signed [VALUE_BITS-1:0] last_t_lo, last_t_hi, last_h_lo, last_h_hi;
    bit  burst_mode;
    int  bad_fields;
    int  words_sent;
    int  quiet_cycles;
    int  n_insert, n_refused, n_select, n_clear, n_nop, max_fill;

    nearest_climate_box_select_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_entry_key   (i_entry_key),
        .i_temp_min    (i_temp_min),
        .i_temp_max    (i_temp_max),
        .i_hum_min     (i_hum_min),
        .i_hum_max     (i_hum_max),
        .i_query_temp  (i_query_temp),
        .i_query_hum   (i_query_hum),
        .o_valid       (o_valid),
        .o_best_key    (o_best_key),
        .o_found       (o_found),
        .o_best_score  (o_best_score),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // doubled-unit distance from q to [lo, hi]; reversed bounds widen it
    function automatic longint axis_gap(input longint q, input longint lo, input longint hi);
        longint off;
        off = 2 * q - (lo + hi);
        if (off < 0) off = -off;
        off = off - (hi - lo);
        return (off > 0) ? off : 0;
    endfunction

    function automatic climate_reply_t predict_nearest_box(input climate_cmd_t cmd);
        climate_reply_t res;
        int     slot;
        longint score, best;
        res.key    = '0;
        res.found  = 1'b0;
        res.score  = '0;
        res.status = 1'b0;
        slot       = -1;
        best       = 0;
        case (cmd.func)
            FUNC_INSERT: begin
                n_insert++;
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (slot < 0 && box_used[i] && box_key[i] == cmd.key) slot = i;
                if (slot < 0) begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (slot < 0 && !box_used[i]) slot = i;
                    if (slot >= 0) box_fill++;
                end
                if (slot < 0) begin
                    res.status = 1'b1;
                    n_refused++;
                end else begin
                    box_used[slot] = 1'b1;
                    box_key[slot]  = cmd.key;
                    box_t_lo[slot] = cmd.t_lo;
                    box_t_hi[slot] = cmd.t_hi;
                    box_h_lo[slot] = cmd.h_lo;
                    box_h_hi[slot] = cmd.h_hi;
                end
                if (box_fill > max_fill) max_fill = box_fill;
            end
            FUNC_CLEAR: begin
                n_clear++;
                for (int i = 0; i < MAX_ENTRIES; i++) box_used[i] = 1'b0;
                box_fill = 0;
            end
            FUNC_SELECT: begin
                n_select++;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (box_used[i]) begin
                        score = axis_gap(cmd.q_t, box_t_lo[i], box_t_hi[i]) ** 2
                              + axis_gap(cmd.q_h, box_h_lo[i], box_h_hi[i]) ** 2;
                        if (score > SCORE_CEIL) score = SCORE_CEIL;
                        // strictly lower only, so the lowest slot keeps a tie
                        if (!res.found || score < best) begin
                            res.found = 1'b1;
                            best      = score;
                            res.key   = box_key[i];
                        end
                    end
                end
                res.score = SCORE_W'(best);
            end
            default: n_nop++;
        endcase
        res.count = CNT_W'(box_fill);
        return res;
    endfunction

    // fields the operation ignores carry noise
    function automatic climate_cmd_t make_word(input logic [FUNC_W-1:0] func);
        climate_cmd_t c;
        c.func = func;
        c.key  = KEY_W'($urandom);
        c.t_lo = VALUE_BITS'($urandom);
        c.t_hi = VALUE_BITS'($urandom);
        c.h_lo = VALUE_BITS'($urandom);
        c.h_hi = VALUE_BITS'($urandom);
        c.q_t  = VALUE_BITS'($urandom);
        c.q_h  = VALUE_BITS'($urandom);
        return c;
    endfunction

    task automatic send_word(input climate_cmd_t cmd);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        // keep start high across back-to-back words
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= cmd.func;
        i_entry_key  <= cmd.key;
        i_temp_min   <= cmd.t_lo;
        i_temp_max   <= cmd.t_hi;
        i_hum_min    <= cmd.h_lo;
        i_hum_max    <= cmd.h_hi;
        i_query_temp <= cmd.q_t;
        i_query_hum  <= cmd.q_h;
        do @(posedge i_clk); while (busy);
        box_replies_due.insert(box_replies_due.size(), predict_nearest_box(cmd));
        words_sent++;
    endtask

    task automatic send_insert(input logic [KEY_W-1:0] key,
                               input logic signed [VALUE_BITS-1:0] t_lo, t_hi, h_lo, h_hi);
        climate_cmd_t c;
        c      = make_word(FUNC_INSERT);
        c.key  = key;
        c.t_lo = t_lo;
        c.t_hi = t_hi;
        c.h_lo = h_lo;
        c.h_hi = h_hi;
        send_word(c);
    endtask

    task automatic send_select(input logic signed [VALUE_BITS-1:0] q_t, q_h);
        climate_cmd_t c;
        c     = make_word(FUNC_SELECT);
        c.q_t = q_t;
        c.q_h = q_h;
        send_word(c);
    endtask

    task automatic send_plain(input logic [FUNC_W-1:0] func);
        send_word(make_word(func));
    endtask

    function automatic void draw_range(output logic signed [VALUE_BITS-1:0] lo, hi);
        int a, w, b;
        case ($urandom_range(0, 9))
            0, 1: begin
                lo = VALUE_BITS'($urandom);
                hi = VALUE_BITS'($urandom);
            end
            2: begin
                lo = VALUE_BITS'($urandom);
                hi = lo;
            end
            default: begin
                a = int'($urandom_range(0, 65535)) - 32768;
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 4096);
                b = a + w;
                if (b > 32767) b = 32767;
                lo = VALUE_BITS'(a);
                hi = VALUE_BITS'(b);
            end
        endcase
    endfunction

    function automatic void draw_query(output logic signed [VALUE_BITS-1:0] q_t, q_h);
        case ($urandom_range(0, 5))
            0: begin
                q_t = $urandom_range(0, 1) ? V_MAX : V_MIN;
                q_h = $urandom_range(0, 1) ? V_MAX : V_MIN;
            end
            1, 2: begin
                // near an edge of the latest box
                q_t = ($urandom_range(0, 1) ? last_t_lo : last_t_hi)
                    + 16'($urandom_range(0, 64)) - 16'd32;
                q_h = ($urandom_range(0, 1) ? last_h_lo : last_h_hi)
                    + 16'($urandom_range(0, 64)) - 16'd32;
            end
            default: begin
                q_t = VALUE_BITS'($urandom);
                q_h = VALUE_BITS'($urandom);
            end
        endcase
    endfunction

    task automatic test_empty_table();
        send_select(16'sd0, 16'sd0);
        send_plain(FUNC_NOP);
        send_plain(FUNC_CLEAR);
        send_select(V_MIN, V_MAX);
    endtask

    task automatic test_extremes();
        send_insert(16'h0000, V_MIN, V_MAX, V_MIN, V_MAX);
        send_insert(16'hFFFF, V_MAX, V_MAX, V_MIN, V_MIN);
        // reversed bounds on both axes
        send_insert(16'h5A5A, V_MAX, V_MIN, 16'sd100, -16'sd100);
        send_select(V_MIN, V_MIN);
        send_select(V_MAX, V_MAX);
        send_select(16'sd0, 16'sd0);
        // identical box under another key: the earlier slot must win
        send_insert(16'hA5A5, V_MIN, V_MAX, V_MIN, V_MAX);
        send_select(16'sd1234, -16'sd1234);
        send_insert(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_select(V_MAX, V_MIN);
        send_select(V_MIN, V_MAX);
        send_plain(FUNC_NOP);
        send_select(16'sd0, 16'sd0);
        send_plain(FUNC_CLEAR);
        send_select(V_MAX, V_MAX);
        send_insert(16'h8001, V_MIN, V_MIN, V_MAX, V_MAX);
        send_select(V_MAX, V_MIN);
    endtask

    task automatic test_full_table();
        logic [KEY_W-1:0]             base;
        logic signed [VALUE_BITS-1:0] t_lo, t_hi, h_lo, h_hi, q_t, q_h;
        base       = KEY_W'($urandom);
        burst_mode = 1'($urandom_range(0, 1));
        send_plain(FUNC_CLEAR);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            draw_range(t_lo, t_hi);
            draw_range(h_lo, h_hi);
            send_insert(base + 16'(i * 1021), t_lo, t_hi, h_lo, h_hi);
        end
        send_insert(base + 16'(MAX_ENTRIES * 1021), V_MIN, V_MAX, V_MIN, V_MAX);
        draw_query(q_t, q_h);
        send_select(q_t, q_h);
        // update of a held key still succeeds when full
        send_insert(base + 16'(37 * 1021), V_MIN, V_MAX, V_MIN, V_MAX);
        send_select(16'sd0, 16'sd0);
        send_insert(~base, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_select(V_MIN, V_MAX);
        burst_mode = 1'b0;
    endtask

    task automatic test_random_mix();
        int                           first, fill_target, phase_len, roll, key_span;
        bit                           narrow;
        logic [KEY_W-1:0]             key_base, key;
        logic signed [VALUE_BITS-1:0] q_t, q_h;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            burst_mode  = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) send_plain(FUNC_CLEAR);
            fill_target = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 70)
                                                      : $urandom_range(1, 16);
            narrow      = ($urandom_range(0, 2) != 0);
            key_base    = KEY_W'($urandom);
            key_span    = fill_target * 2;
            phase_len   = fill_target + $urandom_range(4, 40);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < ((box_fill < fill_target) ? 65 : 25)) begin
                    key = narrow ? key_base + 16'($urandom_range(0, key_span))
                                 : KEY_W'($urandom);
                    // now and then repeat the latest box to force ties
                    if ($urandom_range(0, 7) != 0) begin
                        draw_range(last_t_lo, last_t_hi);
                        draw_range(last_h_lo, last_h_hi);
                    end
                    send_insert(key, last_t_lo, last_t_hi, last_h_lo, last_h_hi);
                end else if (roll < 93) begin
                    draw_query(q_t, q_h);
                    send_select(q_t, q_h);
                end else if (roll < 97) begin
                    send_plain(FUNC_NOP);
                end else begin
                    send_plain(FUNC_CLEAR);
                end
            end
        end
        burst_mode = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_replies
        climate_reply_t due;
        if (i_rst_n && o_valid) begin
            if (box_replies_due.size() == 0) begin
                $error("result strobe with no command outstanding, best_key %h", o_best_key);
                bad_fields++;
            end else begin
                due = box_replies_due.pop_front();
                if (o_best_key !== due.key) begin
                    $error("best_key: expected %h, got %h", due.key, o_best_key);
                    bad_fields++;
                end
                if (o_found !== due.found) begin
                    $error("found: expected %b, got %b", due.found, o_found);
                    bad_fields++;
                end
                if (o_best_score !== due.score) begin
                    $error("best_score: expected %0d, got %0d", due.score, o_best_score);
                    bad_fields++;
                end
                if (o_entry_count !== due.count) begin
                    $error("entry_count: expected %0d, got %0d", due.count, o_entry_count);
                    bad_fields++;
                end
                if (o_status !== due.status) begin
                    $error("status: expected %b, got %b", due.status, o_status);
                    bad_fields++;
                end
            end
        end
    end

    // give up once neither a command nor a result has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        start        <= 1'b0;
        i_rst_n      <= 1'b0;
        i_func       <= FUNC_CLEAR;
        i_entry_key  <= '0;
        i_temp_min   <= '0;
        i_temp_max   <= '0;
        i_hum_min    <= '0;
        i_hum_max    <= '0;
        i_query_temp <= '0;
        i_query_hum  <= '0;
        last_t_lo    = '0;
        last_t_hi    = '0;
        last_h_lo    = '0;
        last_h_hi    = '0;
        box_fill     = 0;
        burst_mode   = 1'b0;
        bad_fields   = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        n_insert     = 0;
        n_refused    = 0;
        n_select     = 0;
        n_clear      = 0;
        n_nop        = 0;
        max_fill     = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) box_used[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_extremes();
        test_full_table();
        test_random_mix();

        start <= 1'b0;
        while (box_replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d words: %0d inserts (%0d refused when full), %0d selects,",
                 words_sent, n_insert, n_refused, n_select);
        $display("%0d clears, %0d unused codes; table filled to %0d of %0d slots at most",
                 n_clear, n_nop, max_fill, MAX_ENTRIES);
        if (bad_fields == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
